[rtl/ridc_pkg.sv]
package ridc_pkg;

  // Item commands
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CHAR  = 2'd2
  } cmd_t;

  // Result codes
  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_MALE    = 2'd1,
    VERDICT_FEMALE  = 2'd2
  } verdict_t;

  // Register indexes (word address bit 2)
  localparam logic REG_YEAR_MIN = 1'b0;
  localparam logic REG_YEAR_MAX = 1'b1;

  localparam int YEAR_W = 14;
  localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1900;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2011;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_REGION_END = 5'd5;   // last region character
  localparam logic [POS_W-1:0] POS_LAST       = 5'd17;  // check character

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_X = 8'h58;

  // Everything the checker needs once the check character is in
  typedef struct packed {
    logic              bad;
    logic              found;
    logic [YEAR_W-1:0] year;
    logic [6:0]        hi2;      // century digits
    logic [6:0]        lo2;      // year within century
    logic [6:0]        month;
    logic [6:0]        day;
    logic [9:0]        seq;
    logic [3:0]        residue;
    logic [7:0]        ch;
  } job_t;

  // 2^(17-i) mod 11
  function automatic logic [3:0] weight(input logic [POS_W-1:0] pos);
    case (pos)
      5'd0:    weight = 4'd7;
      5'd1:    weight = 4'd9;
      5'd2:    weight = 4'd10;
      5'd3:    weight = 4'd5;
      5'd4:    weight = 4'd8;
      5'd5:    weight = 4'd4;
      5'd6:    weight = 4'd2;
      5'd7:    weight = 4'd1;
      5'd8:    weight = 4'd6;
      5'd9:    weight = 4'd3;
      5'd10:   weight = 4'd7;
      5'd11:   weight = 4'd9;
      5'd12:   weight = 4'd10;
      5'd13:   weight = 4'd5;
      5'd14:   weight = 4'd8;
      5'd15:   weight = 4'd4;
      5'd16:   weight = 4'd2;
      default: weight = 4'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month);
    case (month)
      4'd2:    month_days = 5'd28;
      4'd4:    month_days = 5'd30;
      4'd6:    month_days = 5'd30;
      4'd9:    month_days = 5'd30;
      4'd11:   month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

  // v mod 11 for v < 128: quotient by reciprocal 187/2048, exact over this range
  function automatic logic [3:0] mod11(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod  = 15'(v) * 15'd187;
    q     = prod[14:11];
    r     = v - 7'(q * 7'd11);
    mod11 = r[3:0];
  endfunction

endpackage

[rtl/ridc_queue.sv]
module ridc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/ridc_front.sv]
module ridc_front #(
  parameter int REGION_ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      in_command,
  input  logic [19:0]     in_region_code,
  input  logic [7:0]      in_char_code,
  output logic            job_push,
  output ridc_pkg::job_t  job_data,
  input  logic            job_full
);

  import ridc_pkg::*;

  localparam int CNT_W = $clog2(REGION_ENTRIES + 1);
  localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(REGION_ENTRIES);

  logic [19:0]               cell_r [REGION_ENTRIES];
  logic [REGION_ENTRIES-1:0] match_vec_r, match_vec_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [19:0]       region_r, region_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [6:0]        hi2_r, hi2_nxt;
  logic [6:0]        lo2_r, lo2_nxt;
  logic [6:0]        month_r, month_nxt;
  logic [6:0]        day_r, day_nxt;
  logic [9:0]        seq_r, seq_nxt;
  logic [3:0]        residue_r, residue_nxt;
  logic              bad_r, bad_nxt;
  logic              found_r, found_nxt;
  logic              scan_pend_r, scan_pend_nxt;
  logic              match_vld_r, match_vld_nxt;

  logic       acc;
  logic       cell_we;
  cmd_t       cmd;
  logic       is_digit;
  logic [3:0] digit;
  logic [6:0] res_sum;

  assign full     = job_full;
  assign acc      = push && !job_full;
  assign cmd      = cmd_t'(in_command);
  assign is_digit = (in_char_code >= CH_0) && (in_char_code <= CH_9);
  assign digit    = is_digit ? 4'(in_char_code - CH_0) : 4'd0;
  assign res_sum  = 7'(residue_r) + 7'(digit) * 7'(weight(pos_r));

  // Each cell compares against the finished region code
  always_comb begin
    for (int i = 0; i < REGION_ENTRIES; i++) begin
      match_vec_nxt[i] = (cell_r[i] == region_r) && (CNT_W'(i) < count_r);
    end
  end

  always_comb begin
    job_data.bad     = bad_r;
    job_data.found   = found_r;
    job_data.year    = year_r;
    job_data.hi2     = hi2_r;
    job_data.lo2     = lo2_r;
    job_data.month   = month_r;
    job_data.day     = day_r;
    job_data.seq     = seq_r;
    job_data.residue = residue_r;
    job_data.ch      = in_char_code;
  end

  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    region_nxt    = region_r;
    year_nxt      = year_r;
    hi2_nxt       = hi2_r;
    lo2_nxt       = lo2_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    seq_nxt       = seq_r;
    residue_nxt   = residue_r;
    bad_nxt       = bad_r;
    found_nxt     = found_r;
    scan_pend_nxt = 1'b0;
    match_vld_nxt = scan_pend_r;
    cell_we       = 1'b0;
    job_push      = 1'b0;

    // fold in the table scan result
    if (match_vld_r && (|match_vec_r)) begin
      found_nxt = 1'b1;
    end

    if (acc) begin
      case (cmd)
        CMD_CLEAR: begin
          count_nxt     = '0;
          pos_nxt       = '0;
          region_nxt    = '0;
          year_nxt      = '0;
          hi2_nxt       = '0;
          lo2_nxt       = '0;
          month_nxt     = '0;
          day_nxt       = '0;
          seq_nxt       = '0;
          residue_nxt   = '0;
          bad_nxt       = 1'b0;
          found_nxt     = 1'b0;
          scan_pend_nxt = 1'b0;
          match_vld_nxt = 1'b0;
        end
        CMD_ADD: begin
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + 1'b1;
            cell_we   = 1'b1;
            // late add after the scan: compare directly
            if ((pos_r > POS_REGION_END) && (in_region_code == region_r)) begin
              found_nxt = 1'b1;
            end
          end
        end
        CMD_CHAR: begin
          if (pos_r == POS_LAST) begin
            job_push    = 1'b1;
            pos_nxt     = '0;
            region_nxt  = '0;
            year_nxt    = '0;
            hi2_nxt     = '0;
            lo2_nxt     = '0;
            month_nxt   = '0;
            day_nxt     = '0;
            seq_nxt     = '0;
            residue_nxt = '0;
            bad_nxt     = 1'b0;
            found_nxt   = 1'b0;
          end else begin
            if (!is_digit) begin
              bad_nxt = 1'b1;
            end
            case (pos_r) inside
              [5'd0:5'd5]: region_nxt = 20'(region_r * 20'd10 + 20'(digit));
              [5'd6:5'd7]: begin
                year_nxt = 14'(year_r * 14'd10 + 14'(digit));
                hi2_nxt  = 7'(hi2_r * 7'd10 + 7'(digit));
              end
              [5'd8:5'd9]: begin
                year_nxt = 14'(year_r * 14'd10 + 14'(digit));
                lo2_nxt  = 7'(lo2_r * 7'd10 + 7'(digit));
              end
              [5'd10:5'd11]: month_nxt = 7'(month_r * 7'd10 + 7'(digit));
              [5'd12:5'd13]: day_nxt   = 7'(day_r * 7'd10 + 7'(digit));
              default:       seq_nxt   = 10'(seq_r * 10'd10 + 10'(digit));
            endcase
            residue_nxt = mod11(res_sum);
            pos_nxt     = pos_r + 1'b1;
            if (pos_r == POS_REGION_END) begin
              scan_pend_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      region_r    <= '0;
      year_r      <= '0;
      hi2_r       <= '0;
      lo2_r       <= '0;
      month_r     <= '0;
      day_r       <= '0;
      seq_r       <= '0;
      residue_r   <= '0;
      bad_r       <= 1'b0;
      found_r     <= 1'b0;
      scan_pend_r <= 1'b0;
      match_vld_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      region_r    <= region_nxt;
      year_r      <= year_nxt;
      hi2_r       <= hi2_nxt;
      lo2_r       <= lo2_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      seq_r       <= seq_nxt;
      residue_r   <= residue_nxt;
      bad_r       <= bad_nxt;
      found_r     <= found_nxt;
      scan_pend_r <= scan_pend_nxt;
      match_vld_r <= match_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_vec_r <= match_vec_nxt;
    if (cell_we) begin
      cell_r[count_r[IDX_W-1:0]] <= in_region_code;
    end
  end

endmodule

[rtl/ridc_back.sv]
module ridc_back (
  input  logic                       job_empty,
  input  ridc_pkg::job_t             job_data,
  output logic                       job_pop,
  input  logic [ridc_pkg::YEAR_W-1:0] year_min,
  input  logic [ridc_pkg::YEAR_W-1:0] year_max,
  input  logic                       out_full,
  output logic                       out_push,
  output logic [1:0]                 out_verdict
);

  import ridc_pkg::*;

  logic       leap;
  logic [4:0] max_day;
  logic [4:0] expect_sum;
  logic [3:0] expect_val;
  logic       month_ok, day_ok, year_ok, seq_ok, check_ok;
  verdict_t   verdict;

  assign job_pop  = !job_empty && !out_full;
  assign out_push = job_pop;

  always_comb begin
    // century rule works on the two digit pairs
    leap = ((job_data.lo2 != 7'd0) && (job_data.lo2[1:0] == 2'd0)) ||
           ((job_data.lo2 == 7'd0) && (job_data.hi2[1:0] == 2'd0));
    month_ok = (job_data.month >= 7'd1) && (job_data.month <= 7'd12);
    max_day  = month_days(job_data.month[3:0]);
    if ((job_data.month == 7'd2) && leap) begin
      max_day = 5'd29;
    end
    day_ok  = (job_data.day >= 7'd1) && (job_data.day <= 7'(max_day));
    year_ok = (job_data.year >= year_min) && (job_data.year <= year_max);
    seq_ok  = (job_data.seq != 10'd0);

    expect_sum = 5'd12 - 5'(job_data.residue);
    expect_val = (expect_sum >= 5'd11) ? 4'(expect_sum - 5'd11) : expect_sum[3:0];
    if (expect_val == 4'd10) begin
      check_ok = (job_data.ch == CH_X);
    end else begin
      check_ok = (job_data.ch == CH_0 + 8'(expect_val));
    end

    if (!job_data.bad && job_data.found && month_ok && day_ok && year_ok &&
        seq_ok && check_ok) begin
      verdict = job_data.seq[0] ? VERDICT_MALE : VERDICT_FEMALE;
    end else begin
      verdict = VERDICT_INVALID;
    end
    out_verdict = verdict;
  end

endmodule

[rtl/resident_id_number_checker_unit.sv]
// Resident identity number checker. Feed one item per clock: a clear (empties
// the region table and restarts the number), an add (appends a six-digit region
// code, dropped when the table is full, never disturbing a number in flight) or
// an id character. Characters 1-17 are accumulated on the fly: region code, birth
// date, sequence and the MOD 11-2 running residue; once the region code is complete
// all table cells compare against it in parallel, and later adds compare as they
// arrive. The 18th character closes the number and yields one verdict (0 invalid,
// 1 valid male, 2 valid female) via the job queue and the checker into the result
// queue. The block takes one item every cycle; the front stalls (full) only when
// two finished numbers wait for the checker, which in turn waits only on a full
// result queue. The region table has no reset and needs no clearing pass: entries
// above the fill count are ignored. year_min/year_max live at byte addresses 0 and
// 4 and may be changed only when the block is idle.
module resident_id_number_checker_unit #(
  parameter int REGION_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [19:0] in_region_code,
  input  logic [7:0]  in_char_code,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_verdict,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ridc_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  logic [YEAR_W-1:0] year_min_r, year_max_r;
  logic              cfg_wr;

  job_t       job_in, job_out;
  logic       job_push, job_full, job_pop, job_empty;
  logic       out_push, out_full;
  logic [1:0] back_verdict;

  // Config registers: write on the access phase, read back zero-extended
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_YEAR_MAX) ? 32'(year_max_r) : 32'(year_min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_min_r <= YEAR_MIN_RST;
      year_max_r <= YEAR_MAX_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_YEAR_MIN) begin
        year_min_r <= pwdata[YEAR_W-1:0];
      end else begin
        year_max_r <= pwdata[YEAR_W-1:0];
      end
    end
  end

  // Front: accept, classify and accumulate
  ridc_front #(
    .REGION_ENTRIES(REGION_ENTRIES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_region_code (in_region_code),
    .in_char_code   (in_char_code),
    .job_push       (job_push),
    .job_data       (job_in),
    .job_full       (job_full)
  );

  // Finished numbers wait here for the checker
  ridc_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .full    (job_full),
    .wr_data (job_in),
    .pop     (job_pop),
    .empty   (job_empty),
    .rd_data (job_out)
  );

  // Back: judge region hit, date, year range, sequence and check character
  ridc_back u_back (
    .job_empty   (job_empty),
    .job_data    (job_out),
    .job_pop     (job_pop),
    .year_min    (year_min_r),
    .year_max    (year_max_r),
    .out_full    (out_full),
    .out_push    (out_push),
    .out_verdict (back_verdict)
  );

  // Verdicts hold here until popped
  ridc_queue #(
    .WIDTH (2),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .full    (out_full),
    .wr_data (back_verdict),
    .pop     (pop),
    .empty   (empty),
    .rd_data (out_verdict)
  );

  // A finished number never meets a full job queue
  a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job pushed into full queue");

  // The checker only hands over a verdict when there is room
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("verdict pushed into full queue");

  // A pushed job is visible to the checker on the next cycle
  a_job_seen: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> !job_empty)
    else $error("job lost after push");

endmodule

[dv/ridc_checker.sv]
module ridc_checker #(
  parameter int REGION_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_command,
  input  logic [19:0] in_region_code,
  input  logic [7:0]  in_char_code,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_verdict,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ridc_pkg::*;

  // weight of character i is 2^(17-i) mod 11; index 0 is the rightmost entry
  localparam logic [16:0][3:0] WEIGHTS = {4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9, 4'd7, 4'd3,
                                          4'd6, 4'd1, 4'd2, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9,
                                          4'd7};
  // days per month, January at index 0
  localparam logic [11:0][4:0] MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                            5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

  logic [19:0]       regions [REGION_ENTRIES];
  int unsigned       n_regions;
  logic [POS_W-1:0]  pos;
  logic [19:0]       region_acc;
  logic [YEAR_W-1:0] year_acc;
  logic [6:0]        month_acc;
  logic [6:0]        day_acc;
  logic [9:0]        seq_acc;
  logic [3:0]        residue;
  logic              bad;
  logic [YEAR_W-1:0] lo_year;
  logic [YEAR_W-1:0] hi_year;
  verdict_t          verdict_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic restart_number();
    pos        = '0;
    region_acc = '0;
    year_acc   = '0;
    month_acc  = '0;
    day_acc    = '0;
    seq_acc    = '0;
    residue    = '0;
    bad        = 1'b0;
  endtask

  // grade the finished number: region, date, year range, sequence and check character
  function automatic verdict_t grade_number(input logic [7:0] ch);
    int limit;
    int want;
    bit hit;
    hit = 1'b0;
    if (bad) return VERDICT_INVALID;
    for (int i = 0; i < n_regions; i++)
      if (regions[i] == region_acc) hit = 1'b1;
    if (!hit) return VERDICT_INVALID;
    if (month_acc < 1 || month_acc > 12) return VERDICT_INVALID;
    limit = int'(MONTH_LEN[month_acc - 1]);
    if (month_acc == 2 &&
        ((year_acc % 4 == 0 && year_acc % 100 != 0) || year_acc % 400 == 0))
      limit = 29;
    if (day_acc < 1 || day_acc > limit) return VERDICT_INVALID;
    if (year_acc < lo_year || year_acc > hi_year) return VERDICT_INVALID;
    if (seq_acc == 0) return VERDICT_INVALID;
    want = (12 - residue) % 11;
    if (want == 10 ? (ch != CH_X) : (ch != CH_0 + want)) return VERDICT_INVALID;
    return seq_acc[0] ? VERDICT_MALE : VERDICT_FEMALE;
  endfunction

  task automatic absorb_item(input logic [1:0] cmd, input logic [19:0] code,
                             input logic [7:0] ch);
    int d;
    case (cmd)
      CMD_CLEAR: begin
        n_regions = 0;
        restart_number();
      end
      CMD_ADD: begin
        if (n_regions < REGION_ENTRIES) begin
          regions[n_regions] = code;
          n_regions++;
        end
      end
      CMD_CHAR: begin
        if (pos >= POS_LAST) begin
          verdict_q.push_back(grade_number(ch));
          restart_number();
        end else begin
          if (ch >= CH_0 && ch <= CH_9) begin
            d = int'(ch - CH_0);
          end else begin
            d   = 0;
            bad = 1'b1;
          end
          if (pos <= POS_REGION_END) region_acc = 20'(region_acc * 10 + d);
          else if (pos < 10) year_acc = 14'(year_acc * 10 + d);
          else if (pos < 12) month_acc = 7'(month_acc * 10 + d);
          else if (pos < 14) day_acc = 7'(day_acc * 10 + d);
          else seq_acc = 10'(seq_acc * 10 + d);
          residue = 4'((residue + d * WEIGHTS[pos]) % 11);
          pos++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_regions = 0;
      lo_year   = YEAR_MIN_RST;
      hi_year   = YEAR_MAX_RST;
      restart_number();
      verdict_q.delete();
    end else begin
      // a result leaving now was caused by an earlier item: check it first
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %0d with none expected", out_verdict));
        end else begin
          if (out_verdict !== verdict_q[0])
            flag_mismatch($sformatf("verdict %0d, expected %0d", out_verdict, verdict_q[0]));
          void'(verdict_q.pop_front());
        end
      end
      if (push && !full) absorb_item(in_command, in_region_code, in_char_code);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_YEAR_MAX) hi_year = pwdata[YEAR_W-1:0];
          else lo_year = pwdata[YEAR_W-1:0];
        end else if (prdata !== {{(32-YEAR_W){1'b0}},
                                 (paddr[2] == REG_YEAR_MAX) ? hi_year : lo_year}) begin
          flag_mismatch($sformatf("register read at %0d gave %0d", paddr, prdata));
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ridc_pkg::*;

  // command code the block must ignore
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam logic [7:0] CH_LOWER_X     = 8'h78;
  // longest stretch without any accepted item before the run is called hung
  localparam int         WATCHDOG_LIMIT = 4000;
  // receiver hold-off that lets the block back up into its input
  localparam int         HOLD_CYCLES    = 500;
  // cycles to let clears and adds drain before touching registers
  localparam int         SETTLE_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = CMD_CLEAR;
  logic [19:0] in_region_code = '0;
  logic [7:0]  in_char_code = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_verdict;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic [19:0] loaded [$];     // codes added since the last clear, for building numbers
  logic [13:0] cur_lo = YEAR_MIN_RST;
  logic [13:0] cur_hi = YEAR_MAX_RST;
  bit          hold_req = 1'b0;
  bit          burst_in = 1'b0;  // sender runs without gaps while set
  bit          burst_out = 1'b0; // receiver pops without gaps while set

  always #1 clk = ~clk;

  resident_id_number_checker_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_region_code (in_region_code),
    .in_char_code   (in_char_code),
    .empty          (empty),
    .pop            (pop),
    .out_verdict    (out_verdict),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  ridc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_command     (in_command),
    .in_region_code (in_region_code),
    .in_char_code   (in_char_code),
    .empty          (empty),
    .pop            (pop),
    .out_verdict    (out_verdict),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // Offer one item after a random gap and hold it until the block takes it.
  // Enter and leave at a falling edge; push stays high on return so that a
  // back-to-back item never sees it dip.
  task automatic send_item(input logic [1:0] cmd, input logic [19:0] code,
                           input logic [7:0] ch);
    int gap;
    if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
    gap = burst_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push           <= 1'b1;
    in_command     <= cmd;
    in_region_code <= code;
    in_char_code   <= ch;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
    // mirror the table contents so numbers can pick a loaded region
    if (cmd == CMD_CLEAR) loaded.delete();
    else if (cmd == CMD_ADD) loaded.push_back(code);
  endtask

  // Write one year bound, then read it back so the checker sees the value.
  // Leave the bus idle before returning.
  task automatic program_year(input logic idx, input logic [13:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {18'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_YEAR_MAX) cur_hi = val;
    else cur_lo = val;
    @(negedge clk);
  endtask

  // Drop push, wait for every verdict to come out, then let the pipe go quiet.
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_regions(input int count);
    for (int k = 0; k < count; k++)
      send_item(CMD_ADD, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
  endtask

  // Build one 18-character number and send it. A clean number is well formed
  // and valid under the current bounds; otherwise every field may be bent:
  // foreign regions, dates off the calendar, zero sequence, wrong or
  // lowercase check character, a stray byte in the body, or a number cut
  // short by a clear. Adds and ignored commands may slip in between
  // characters.
  task automatic send_id_number(input bit clean);
    logic [7:0] digits [18];
    int region, year, month, day, seq;
    int resid, w, chk, count, ylo, yhi, r;
    ylo = int'((cur_lo < cur_hi) ? cur_lo : cur_hi);
    yhi = int'((cur_lo < cur_hi) ? cur_hi : cur_lo);

    if (loaded.size() > 0 && (clean || $urandom_range(0, 9) < 8))
      region = int'(loaded[$urandom_range(0, loaded.size() - 1)]);
    else
      region = $urandom_range(0, 999999);

    if (clean) begin
      year = $urandom_range(cur_lo, cur_hi);
    end else begin
      case ($urandom_range(0, 9))
        // century and leap corners: 1900, 1904, 2000, 2004, 2100, 2104
        0:       year = 1900 + 100 * $urandom_range(0, 2) + 4 * $urandom_range(0, 1);
        1:       year = $urandom_range(0, 9999);
        default: year = $urandom_range(ylo > 3 ? ylo - 3 : 0, yhi < 9996 ? yhi + 3 : 9999);
      endcase
    end

    month = (clean || $urandom_range(0, 9) > 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    if (!clean && $urandom_range(0, 4) == 0) month = 2;

    r = clean ? 0 : $urandom_range(0, 19);
    if (r < 13) day = $urandom_range(1, 28);
    else if (r < 19) day = $urandom_range(29, 31);
    else day = $urandom_range(0, 99);

    seq = (clean || $urandom_range(0, 19) > 0) ? $urandom_range(1, 999) : 0;

    // spell the fields out as ASCII digits, least significant last
    for (int k = 5; k >= 0; k--) begin
      digits[k] = CH_0 + 8'(region % 10);
      region    = region / 10;
    end
    for (int k = 9; k >= 6; k--) begin
      digits[k] = CH_0 + 8'(year % 10);
      year      = year / 10;
    end
    for (int k = 11; k >= 10; k--) begin
      digits[k] = CH_0 + 8'(month % 10);
      month     = month / 10;
    end
    for (int k = 13; k >= 12; k--) begin
      digits[k] = CH_0 + 8'(day % 10);
      day       = day / 10;
    end
    for (int k = 16; k >= 14; k--) begin
      digits[k] = CH_0 + 8'(seq % 10);
      seq       = seq / 10;
    end

    // running weight doubles mod 11 from the right
    resid = 0;
    w     = 1;
    for (int k = 16; k >= 0; k--) begin
      w     = (w * 2) % 11;
      resid = resid + (digits[k] - CH_0) * w;
    end
    chk = (12 - resid % 11) % 11;
    digits[17] = (chk == 10) ? CH_X : CH_0 + 8'(chk);

    if (!clean) begin
      case ($urandom_range(0, 19))
        15:      digits[17] = CH_LOWER_X;
        16:      digits[17] = CH_X;
        17, 18:  digits[17] = CH_0 + 8'($urandom_range(0, 9));
        19:      digits[17] = 8'($urandom_range(0, 255));
        default: ;
      endcase
      if ($urandom_range(0, 11) == 0)
        digits[$urandom_range(0, 16)] = 8'($urandom_range(0, 255));
    end

    count = (!clean && $urandom_range(0, 19) == 0) ? $urandom_range(1, 17) : 18;
    for (int k = 0; k < count; k++) begin
      if (!clean) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          send_item(CMD_ADD, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
        else if (r < 6)
          send_item(CMD_UNUSED, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
      end
      send_item(CMD_CHAR, 20'($urandom_range(0, 999999)), digits[k]);
    end
    // a cut-off number: restart and put a few regions back
    if (count < 18) begin
      send_item(CMD_CLEAR, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
      load_regions($urandom_range(1, 4));
    end
  endtask

  // Receiver: pop after a random wait; on request hold off for a long stretch
  // so the result side fills and the block stalls its input.
  initial begin
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 39) == 0) burst_out = !burst_out;
      gap = burst_out ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_end;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: clear, extreme region codes, an ignored command, one valid number.
    send_item(CMD_CLEAR, 20'd0, 8'd0);
    send_item(CMD_ADD, 20'd0, 8'hFF);
    send_item(CMD_ADD, 20'd999999, 8'd0);
    send_item(CMD_ADD, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
    send_item(CMD_UNUSED, 20'd999999, 8'hFF);
    send_id_number(1'b1);

    // Random phases, each under its own year bounds.
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: ;  // keep reset bounds
        1: begin
          program_year(REG_YEAR_MIN, 14'd0);
          program_year(REG_YEAR_MAX, 14'd9999);
        end
        2: begin  // inverted bounds: nothing passes the year test
          program_year(REG_YEAR_MIN, 14'd2000);
          program_year(REG_YEAR_MAX, 14'd1990);
        end
        3: begin
          program_year(REG_YEAR_MAX, 14'd9999);
          program_year(REG_YEAR_MIN, 14'd9999);
        end
        4: begin
          program_year(REG_YEAR_MIN, 14'd0);
          program_year(REG_YEAR_MAX, 14'd0);
        end
        default: begin
          program_year(REG_YEAR_MIN, 14'($urandom_range(1800, 2100)));
          program_year(REG_YEAR_MAX, 14'($urandom_range(1900, 9999)));
        end
      endcase
      // back up the result side while the sender streams in
      if (p == 2) begin
        hold_req = 1'b1;
        burst_in = 1'b1;
      end
      // overfill the table once so the late adds are dropped
      load_regions(p == 3 ? 66 : $urandom_range(1, 8));
      phase_end = items_sent + ((p == 2) ? 400 : 170);
      while (items_sent < phase_end) send_id_number(1'b0);
      send_item(CMD_CLEAR, 20'($urandom_range(0, 999999)), 8'($urandom_range(0, 255)));
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
